// File: src/sfsd_pkg.sv
package sfsd_pkg;

    localparam int HI_WIDTH  = 128;
    localparam int HI_HEIGHT = 64;
    localparam int LO_WIDTH  = 64;
    localparam int LO_HEIGHT = 32;
    localparam int SHIFT_COLS = 4;
    localparam int SPRITE_BITS = 16;
    localparam int ROW_AW = $clog2(HI_HEIGHT);
    localparam int COL_AW = $clog2(HI_WIDTH);

    typedef enum logic [2:0] {
        CMD_HIRES   = 3'd0,
        CMD_LORES   = 3'd1,
        CMD_SCR_DN  = 3'd2,
        CMD_SCR_RT  = 3'd3,
        CMD_SCR_LT  = 3'd4,
        CMD_DRAW    = 3'd5,
        CMD_NOP6    = 3'd6,
        CMD_NOP7    = 3'd7
    } t_cmd;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  scroll_amount;
        logic [7:0]  x_coord;
        logic [7:0]  y_coord;
        logic [15:0] sprite_row;
        logic [3:0]  row_index;
    } t_in;

    typedef struct packed {
        logic collision;
        logic done_res;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD,
        ST_WAIT,
        ST_WR,
        ST_RESP
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic               load;      // latch the command
        logic               clr_wr;    // write zero row at row counter
        logic               rd;        // read source row
        logic               wr;        // write modified row
        logic [ROW_AW-1:0]  row;       // row counter
    } t_ctl;

    // status from datapath to controller
    typedef struct packed {
        logic              sweep;      // command touches rows
        logic [ROW_AW:0]   rows;       // row count of sweep
    } t_sts;

endpackage

// File: src/sfsd_datapath.sv
module sfsd_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sfsd_pkg::t_in          i_item,
    input  sfsd_pkg::t_ctl         i_ctl,
    output sfsd_pkg::t_sts         o_sts,
    output sfsd_pkg::t_out         o_res
);
    import sfsd_pkg::*;

    logic [HI_WIDTH-1:0] mem [HI_HEIGHT];
    logic [HI_WIDTH-1:0] r_rdata;
    logic [HI_WIDTH-1:0] r_keep;
    t_in                 r_item;
    logic                r_hi;
    logic                n_hi;
    logic                r_coll;
    logic                n_coll;
    logic [HI_WIDTH-1:0] w_new;
    logic [HI_WIDTH-1:0] w_act;
    logic [HI_WIDTH-1:0] w_spr;
    logic [ROW_AW:0]     w_h;
    logic [COL_AW:0]     w_w;
    logic [ROW_AW-1:0]   w_src;
    logic [ROW_AW:0]     w_y;
    logic [COL_AW-1:0]   w_x0;
    logic                w_top;
    logic                w_drawok;

    // the sprite row index order in bits: column c is bit c
    assign w_h  = r_hi ? (ROW_AW+1)'(HI_HEIGHT) : (ROW_AW+1)'(LO_HEIGHT);
    assign w_w  = r_hi ? (COL_AW+1)'(HI_WIDTH)  : (COL_AW+1)'(LO_WIDTH);
    assign w_act = r_hi ? {HI_WIDTH{1'b1}} : HI_WIDTH'({LO_WIDTH{1'b1}});
    assign w_y  = (r_hi ? (ROW_AW+1)'(r_item.y_coord[ROW_AW-1:0])
                        : (ROW_AW+1)'(r_item.y_coord[$clog2(LO_HEIGHT)-1:0]))
                  + (ROW_AW+1)'(r_item.row_index);
    assign w_x0 = r_hi ? r_item.x_coord[COL_AW-1:0]
                       : COL_AW'(r_item.x_coord[$clog2(LO_WIDTH)-1:0]);
    assign w_drawok = (w_y < w_h);
    assign w_top = ({1'b0, i_ctl.row} < (ROW_AW+1)'(r_item.scroll_amount));
    assign w_src = i_ctl.row - ROW_AW'(r_item.scroll_amount);

    function automatic logic [HI_WIDTH-1:0] mem_keep();
        return r_keep & ~w_act;
    endfunction

    always_comb begin
        for (int c = 0; c < HI_WIDTH; c++) begin
            w_spr[c] = 1'b0;
            for (int k = 0; k < SPRITE_BITS; k++) begin
                if ((COL_AW+1)'(w_x0) + (COL_AW+1)'(k) == (COL_AW+1)'(c)) begin
                    w_spr[c] = r_item.sprite_row[SPRITE_BITS-1-k];
                end
            end
        end
        w_spr = w_spr & w_act;
    end

    always_comb begin
        n_coll = r_coll;
        case (t_cmd'(r_item.command))
            // rows moving in at the top are cleared
            CMD_SCR_DN: w_new = w_top ? mem_keep() : ((r_rdata & w_act) | mem_keep());
            CMD_SCR_RT: w_new = ((r_rdata << SHIFT_COLS) & w_act) | (r_rdata & ~w_act);
            CMD_SCR_LT: w_new = ((r_rdata >> SHIFT_COLS) & w_act
                                 & ~(w_act << (w_w - SHIFT_COLS))) | (r_rdata & ~w_act);
            CMD_DRAW: begin
                w_new = r_rdata ^ w_spr;
                if (i_ctl.wr && |(r_rdata & w_spr)) begin
                    n_coll = 1'b1;
                end
            end
            default: w_new = r_rdata;
        endcase
        // first row of a sprite starts a fresh collision flag
        if (i_ctl.load && t_cmd'(i_item.command) == CMD_DRAW && i_item.row_index == 4'd0) begin
            n_coll = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rdata <= mem[(t_cmd'(r_item.command) == CMD_SCR_DN) ? w_src :
                           (t_cmd'(r_item.command) == CMD_DRAW) ? w_y[ROW_AW-1:0] : i_ctl.row];
            r_keep  <= mem[i_ctl.row];
        end
        if (i_ctl.clr_wr) begin
            mem[i_ctl.row] <= '0;
        end else if (i_ctl.wr) begin
            mem[(t_cmd'(r_item.command) == CMD_DRAW) ? w_y[ROW_AW-1:0] : i_ctl.row] <= w_new;
        end
        if (i_ctl.load) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        n_hi = r_hi;
        if (i_ctl.load && t_cmd'(i_item.command) == CMD_HIRES) n_hi = 1'b1;
        if (i_ctl.load && t_cmd'(i_item.command) == CMD_LORES) n_hi = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi   <= 1'b0;
            r_coll <= 1'b0;
        end else begin
            r_hi   <= n_hi;
            r_coll <= n_coll;
        end
    end

    always_comb begin
        o_sts.sweep     = 1'b0;
        o_sts.rows      = w_h;
        case (t_cmd'(r_item.command))
            CMD_SCR_DN, CMD_SCR_RT, CMD_SCR_LT: o_sts.sweep = 1'b1;
            CMD_DRAW: begin
                o_sts.sweep = w_drawok;
                o_sts.rows  = (ROW_AW+1)'(1);
            end
            default: o_sts.sweep = 1'b0;
        endcase
        o_res.collision = (t_cmd'(r_item.command) == CMD_DRAW) ? r_coll : 1'b0;
        o_res.done_res  = (t_cmd'(r_item.command) == CMD_DRAW) ?
                          (r_item.row_index == 4'd15) : 1'b1;
    end

endmodule

// File: src/sfsd_ctrl.sv
module sfsd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  sfsd_pkg::t_sts       i_sts,
    output sfsd_pkg::t_ctl       o_ctl,
    output logic                 o_busy,
    output logic                 o_strobe
);
    import sfsd_pkg::*;

    t_state            r_state, n_state;
    logic [ROW_AW:0]   r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (ROW_AW+1)'(HI_HEIGHT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RD;
                    n_cnt   = '0;
                end
            end
            ST_RD: n_state = i_sts.sweep ? ST_WAIT : ST_RESP;
            ST_WAIT: n_state = ST_WR;
            ST_WR: begin
                n_cnt = r_cnt + 1'b1;
                n_state = (r_cnt + 1'b1 >= i_sts.rows) ? ST_RESP : ST_RD;
            end
            ST_RESP: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // scrolls walk rows bottom up, the clearing pass top down
    logic [ROW_AW-1:0] w_row;
    always_comb begin
        w_row = r_cnt[ROW_AW-1:0];
        if (r_state != ST_CLEAR && i_sts.rows != (ROW_AW+1)'(1)) begin
            w_row = ROW_AW'(i_sts.rows - 1'b1 - r_cnt);
        end
    end

    always_comb begin
        o_ctl.load   = (r_state == ST_IDLE) && i_start;
        o_ctl.clr_wr = (r_state == ST_CLEAR);
        o_ctl.rd     = (r_state == ST_RD);
        o_ctl.wr     = (r_state == ST_WR);
        o_ctl.row    = w_row;
        o_busy       = (r_state != ST_IDLE);
        o_strobe     = (r_state == ST_RESP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// File: src/sprite_framebuffer_scroll_draw.sv
// display engine: one-bit framebuffer with mode select, scrolls and sprite row
// xor. after reset a clearing pass over all 64 rows runs with busy high. mode and
// unused commands and clipped draw rows go from the read state straight to the
// response; a draw row and every row of a scroll pass through read, wait and
// write, a row at a time. the receiver cannot stall: the result transfer
// is the one cycle o_strobe is high, and busy stays high until then
module sprite_framebuffer_scroll_draw (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  sfsd_pkg::t_in    i_item,
    output logic             o_strobe,
    output sfsd_pkg::t_out   o_res
);
    import sfsd_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    // sequencer
    sfsd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sts    (w_sts),
        .o_ctl    (w_ctl),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    // frame ram and row arithmetic
    sfsd_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts),
        .o_res   (o_res)
    );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

import sfsd_pkg::*;

// frame model and expected-result store for the display engine
class display_scoreboard;
    bit        frame [HI_HEIGHT][HI_WIDTH];
    bit        hi_mode;
    bit        hit_seen;
    t_out      pending [$];
    int        n_fail;
    int        n_checked;

    function void clear_all();
        foreach (frame[r, c]) frame[r][c] = 1'b0;
        hi_mode  = 1'b0;
        hit_seen = 1'b0;
        pending.delete();
        n_fail    = 0;
        n_checked = 0;
    endfunction

    // apply one accepted command to the frame model and queue its answer
    function void note_command(t_in it);
        int   w;
        int   h;
        int   row;
        int   col0;
        t_out ans;
        w = hi_mode ? HI_WIDTH : LO_WIDTH;
        h = hi_mode ? HI_HEIGHT : LO_HEIGHT;
        ans.collision = 1'b0;
        ans.done_res  = 1'b1;
        case (t_cmd'(it.command))
            CMD_HIRES: hi_mode = 1'b1;
            CMD_LORES: hi_mode = 1'b0;
            CMD_SCR_DN: begin
                for (int y = h - 1; y >= 0; y--)
                    for (int x = 0; x < w; x++)
                        frame[y][x] = (y < it.scroll_amount) ? 1'b0
                                      : frame[y - it.scroll_amount][x];
            end
            CMD_SCR_RT: begin
                for (int y = 0; y < h; y++)
                    for (int x = w - 1; x >= 0; x--)
                        frame[y][x] = (x < SHIFT_COLS) ? 1'b0 : frame[y][x - SHIFT_COLS];
            end
            CMD_SCR_LT: begin
                for (int y = 0; y < h; y++)
                    for (int x = 0; x < w; x++)
                        frame[y][x] = (x + SHIFT_COLS >= w) ? 1'b0
                                      : frame[y][x + SHIFT_COLS];
            end
            CMD_DRAW: begin
                row  = (it.y_coord % h) + it.row_index;
                col0 = it.x_coord % w;
                if (it.row_index == 0) hit_seen = 1'b0;
                if (row < h) begin
                    for (int k = 0; k < SPRITE_BITS; k++) begin
                        if (col0 + k < w && it.sprite_row[SPRITE_BITS - 1 - k]) begin
                            if (frame[row][col0 + k]) hit_seen = 1'b1;
                            frame[row][col0 + k] ^= 1'b1;
                        end
                    end
                end
                ans.collision = hit_seen;
                ans.done_res  = (it.row_index == 4'd15);
            end
            default: ;
        endcase
        pending.push_back(ans);
    endfunction

    function void check_result(t_out got);
        t_out want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %b", $time, got);
            n_fail++;
            return;
        end
        want = pending.pop_front();
        n_checked++;
        if (got.collision !== want.collision) begin
            $display("%0t: collision expected %b actual %b", $time, want.collision,
                     got.collision);
            n_fail++;
        end
        if (got.done_res !== want.done_res) begin
            $display("%0t: done_res expected %b actual %b", $time, want.done_res,
                     got.done_res);
            n_fail++;
        end
    endfunction
endclass

module tb_top;
    localparam int N_RANDOM   = 1230;
    localparam int IDLE_LIMIT = 4000;   // slowest command is a full-height scroll
    localparam int IN_W       = $bits(t_in);

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_in    i_item;
    logic   o_strobe;
    t_out   o_res;

    display_scoreboard sb;
    int     idle_cycles;
    bit     calm;          // no idling in the closing stretch
    int     n_draws;
    int     n_scrolls;

    sprite_framebuffer_scroll_draw u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // result checking and the watchdog run on every rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) sb.check_result(o_res);
            if ((start && !busy) || o_strobe) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog expired, no transfer for %0d cycles", $time,
                         idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // present one command and hold it until the transfer happens
    task automatic send_command(t_in it);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_command(it);
        if (t_cmd'(it.command) == CMD_DRAW) n_draws++;
        if (it.command inside {CMD_SCR_DN, CMD_SCR_RT, CMD_SCR_LT}) n_scrolls++;
    endtask

    function automatic t_in make_cmd(t_cmd c);
        t_in it;
        it = t_in'(IN_W'({$urandom, $urandom}));
        it.command = c;
        return it;
    endfunction

    function automatic t_in make_draw(logic [7:0] x, logic [7:0] y, logic [15:0] bits,
                                      logic [3:0] idx);
        t_in it;
        it = make_cmd(CMD_DRAW);
        it.x_coord    = x;
        it.y_coord    = y;
        it.sprite_row = bits;
        it.row_index  = idx;
        return it;
    endfunction

    // a whole sprite of sixteen rows, mostly well formed
    task automatic send_sprite();
        logic [7:0] x;
        logic [7:0] y;
        x = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 70));
        y = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 40));
        for (int r = 0; r < 16; r++)
            send_command(make_draw(x, y, 16'($urandom), 4'(r)));
    endtask

    initial begin
        t_in it;
        int  sel;
        int  sent;
        sb = new();
        sb.clear_all();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        idle_cycles = 0;
        calm        = 1'b0;
        n_draws     = 0;
        n_scrolls   = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: draws at edges and wrap, collision, clipping, every command
        send_command(make_draw(8'd0, 8'd0, 16'hFFFF, 4'd0));
        send_command(make_draw(8'd0, 8'd0, 16'h8001, 4'd0));
        send_command(make_draw(8'd60, 8'd31, 16'hFFFF, 4'd0));
        send_command(make_draw(8'd255, 8'd255, 16'hA5A5, 4'd1));
        send_command(make_draw(8'd2, 8'd20, 16'h0000, 4'd15));
        send_command(make_draw(8'd64, 8'd32, 16'hFFFF, 4'd15));
        it = make_cmd(CMD_SCR_DN); it.scroll_amount = 4'd0;  send_command(it);
        it = make_cmd(CMD_SCR_DN); it.scroll_amount = 4'd15; send_command(it);
        send_command(make_cmd(CMD_SCR_RT));
        send_command(make_cmd(CMD_SCR_LT));
        send_command(make_cmd(CMD_NOP6));
        send_command(make_cmd(CMD_NOP7));
        send_command(make_cmd(CMD_HIRES));
        send_command(make_draw(8'd120, 8'd63, 16'hFFFF, 4'd0));
        send_command(make_draw(8'd127, 8'd0, 16'hFFFF, 4'd15));
        send_command(make_draw(8'd255, 8'd255, 16'hFFFF, 4'd0));
        send_command(make_draw(8'd255, 8'd255, 16'hFFFF, 4'd0));
        it = make_cmd(CMD_SCR_DN); it.scroll_amount = 4'd7; send_command(it);
        send_command(make_cmd(CMD_SCR_LT));
        send_command(make_cmd(CMD_SCR_RT));
        send_command(make_cmd(CMD_LORES));

        // random: mostly whole sprites, some scrolls, mode flips and noise
        sent = 0;
        while (sent < N_RANDOM) begin
            if (sent > N_RANDOM - 150) calm = 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                send_sprite();
                sent += 16;
            end else if (sel < 60) begin
                send_command(make_cmd(CMD_DRAW));
                sent++;
            end else if (sel < 75) begin
                send_command(make_cmd(sel < 65 ? CMD_SCR_DN : sel < 70 ? CMD_SCR_RT
                                                               : CMD_SCR_LT));
                sent++;
            end else if (sel < 90) begin
                send_command(make_cmd(sel < 82 ? CMD_HIRES : CMD_LORES));
                sent++;
            end else begin
                send_command(t_in'(IN_W'({$urandom, $urandom})));
                sent++;
            end
        end
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d draw rows and %0d scrolls; %0d results checked",
                 n_draws, n_scrolls, sb.n_checked);
        if (sb.n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
